// File: design/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // Block size in bytes; it must be a power of two.
    localparam int unsigned BLOCK_BYTES = 32;
    localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);

    localparam int unsigned DEF_NUM_BLOCKS = 1024;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [COUNT_W-1:0] RESET_BLOCK_COUNT = 11'd1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_BASE   = 1'd1;

    // Request commands.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

    // Outcome of the address checks on a free request.
    typedef struct packed {
        logic not_null;
        logic aligned;
        logic in_range;
        logic touched;
    } t_free_chk;

endpackage

// File: design/fbpa_addr_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_addr_check
// Turns a free address into a block index and checks it against the pool.
// ----------------------------------------------------------------------------
module fbpa_addr_check
    import fbpa_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = DEF_NUM_BLOCKS
) (
    input  logic [ADDR_W-1:0]                   i_addr,
    input  logic [ADDR_W-1:0]                   i_base,
    input  logic [$clog2(NUM_BLOCKS+1)-1:0]     i_count,
    input  logic [$clog2(NUM_BLOCKS+1)-1:0]     i_mark,
    output logic [$clog2(NUM_BLOCKS)-1:0]       o_idx,
    output t_free_chk                           o_chk
);

    logic [ADDR_W-1:0] w_off;
    logic [ADDR_W-1:0] w_off_idx;

    assign w_off     = i_addr - i_base;
    assign w_off_idx = w_off >> BLOCK_SHIFT;
    assign o_idx     = w_off_idx[$clog2(NUM_BLOCKS)-1:0];

    // Blocks at or above the watermark have not been handed out since the
    // last rebuild, so their stored flag is stale and reads as clear.
    always_comb begin
        o_chk.not_null = (i_addr != '0);
        o_chk.aligned  = (w_off[BLOCK_SHIFT-1:0] == '0);
        o_chk.in_range = (w_off_idx < ADDR_W'(i_count));
        o_chk.touched  = (w_off_idx < ADDR_W'(i_mark));
    end

endmodule

// File: design/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block allocator with a LIFO free list kept in a block memory.
//
//  Channel  Direction  Signals                        Contents
//  s        in         i_s_tvalid/o_s_tready          tuser: command
//                      i_s_tdata[31:0], i_s_tuser     tdata: free_address
//  m        out        o_m_tvalid/i_m_tready          tdata: block_address,
//                      o_m_tdata[39:0]                status, zero pad
//  cfg      in         i_cfg_valid/o_cfg_ready        index 0 block_count,
//                      i_cfg_index, i_cfg_data        index 1 area_base
//
// Each request first reads its block memory entry, then checks it, writes it
// back and loads the result register.
// A new request is taken while the previous result waits, if that result
// leaves in the same cycle. Reset or a block_count write rebuilds the pool at
// once; the watermark stands in for a clearing pass over the memory.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS = DEF_NUM_BLOCKS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [ADDR_W-1:0]       i_s_tdata,   // [31:0] free_address
    input  logic                    i_s_tuser,   // [0] command
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OUT_DATA_W-1:0]   o_m_tdata,   // [31:0] block_address,
                                                 // [33:32] status, [39:34] zero
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ADDR_W-1:0]       i_cfg_data
);

    localparam int unsigned IW = $clog2(NUM_BLOCKS);
    localparam int unsigned MW = $clog2(NUM_BLOCKS + 1);
    // Memory entry: allocated flag, link valid, link index.
    localparam int unsigned EW = IW + 2;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_ACCESS = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_block_count;
    logic [ADDR_W-1:0]  r_area_base;
    logic [IW-1:0]      r_head;
    logic               r_head_valid;
    logic [MW-1:0]      r_mark;
    logic               r_cmd;
    logic [IW-1:0]      r_idx;
    logic               r_pop;
    logic               r_ok_pre;
    logic [EW-1:0]      r_mem [NUM_BLOCKS];
    logic [EW-1:0]      r_rd;
    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [STATUS_W-1:0] r_out_status;

    logic [MW-1:0]      w_count;
    logic               w_in_acc;
    logic               w_cfg_acc;
    logic [IW-1:0]      n_idx;
    logic               n_ok_pre;
    logic [IW-1:0]      w_chk_idx;
    t_free_chk          w_chk;
    logic               w_we;
    logic [EW-1:0]      w_wdata;
    logic               w_free_ok;
    logic               w_load;
    logic [ADDR_W-1:0]  n_out_addr;
    logic [STATUS_W-1:0] n_out_status;

    assign w_count = (ADDR_W'(r_block_count) > ADDR_W'(NUM_BLOCKS))
                     ? MW'(NUM_BLOCKS) : MW'(r_block_count);

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid;
    assign o_s_tready  = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign w_in_acc    = i_s_tvalid && o_s_tready;

    fbpa_addr_check #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_addr_check (
        .i_addr  (i_s_tdata),
        .i_base  (r_area_base),
        .i_count (w_count),
        .i_mark  (r_mark),
        .o_idx   (w_chk_idx),
        .o_chk   (w_chk)
    );

    // Pick the entry to read: the list head or the watermark on allocate,
    // the decoded block on free.
    always_comb begin
        if (i_s_tuser == CMD_FREE) begin
            n_idx    = w_chk_idx;
            n_ok_pre = w_chk.not_null && w_chk.aligned && w_chk.in_range
                       && w_chk.touched;
        end else begin
            n_idx    = r_head_valid ? r_head : r_mark[IW-1:0];
            n_ok_pre = r_head_valid || (r_mark < w_count);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_in_acc) n_state = ST_ACCESS;
            ST_ACCESS: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    assign w_free_ok = r_ok_pre && r_rd[EW-1];
    assign w_load    = (r_state == ST_ACCESS);

    always_comb begin
        w_we         = 1'b0;
        w_wdata      = {1'b1, 1'b0, {IW{1'b0}}};
        n_out_addr   = '0;
        n_out_status = STATUS_OK;
        if (r_cmd == CMD_ALLOC) begin
            if (r_ok_pre) begin
                w_we       = w_load;
                n_out_addr = r_area_base + (ADDR_W'(r_idx) << BLOCK_SHIFT);
            end else begin
                n_out_status = STATUS_EMPTY;
            end
        end else begin
            w_wdata = {1'b0, r_head_valid, r_head};
            if (w_free_ok) begin
                w_we = w_load;
            end else begin
                n_out_status = STATUS_REJECTED;
            end
        end
    end

    // The write of one request lands before the read of the next one is
    // issued, so the two never touch the same entry in one cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= w_wdata;
        end
        if (w_in_acc) begin
            r_rd <= r_mem[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= i_s_tuser;
            r_idx    <= n_idx;
            r_pop    <= r_head_valid;
            r_ok_pre <= n_ok_pre;
        end
        if (w_load) begin
            r_out_addr   <= n_out_addr;
            r_out_status <= n_out_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_block_count <= RESET_BLOCK_COUNT;
            r_area_base   <= '0;
            r_head        <= '0;
            r_head_valid  <= 1'b0;
            r_mark        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load && w_we) begin
                if (r_cmd == CMD_ALLOC) begin
                    if (r_pop) begin
                        r_head       <= r_rd[IW-1:0];
                        r_head_valid <= r_rd[IW];
                    end else begin
                        r_mark <= r_mark + MW'(1);
                    end
                end else begin
                    r_head       <= r_idx;
                    r_head_valid <= 1'b1;
                end
            end
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_BLOCK_COUNT: begin
                        r_block_count <= i_cfg_data[COUNT_W-1:0];
                        r_head_valid  <= 1'b0;
                        r_mark        <= '0;
                    end
                    CFG_AREA_BASE: r_area_base <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - ADDR_W - STATUS_W){1'b0}}, r_out_status, r_out_addr};

`ifndef NO_ASSERTIONS
    a_accept_to_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_ACCESS))
        else $error("accepted request did not start a memory access");

    a_access_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCESS) |=> o_m_tvalid)
        else $error("memory access did not produce a result");

    a_mark_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark <= w_count)
        else $error("watermark passed the pool size");

    a_fail_has_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_out_status != STATUS_OK)) |-> (r_out_addr == '0))
        else $error("failed request returned an address");
`endif

endmodule

// File: tb/sv/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// Self-checking bench for the fixed block pool allocator. A clocked driver
// offers queued allocate and free requests, and a clocked monitor compares
// each result with the reply that a local model of the pool predicts. The
// run has a directed part covering null, misaligned, out-of-range, double and
// wrapped frees, a moved base and the count extremes. Random phases follow
// with new pool settings and random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;
    import fbpa_pkg::*;

    localparam int unsigned IDX_W        = $clog2(DEF_NUM_BLOCKS);
    localparam int          PLAN_COPY    = 0;
    localparam int          CHECK_COPY   = 1;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned STUCK_LIMIT  = 2000;
    localparam int unsigned PHASES       = 9;
    localparam int unsigned PHASE_ITEMS  = 116;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] addr;
    } t_pool_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
    } t_pool_reply;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic [ADDR_W-1:0]     i_s_tdata   = '0;
    logic                  i_s_tuser   = CMD_ALLOC;
    logic                  i_m_tready  = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_BLOCK_COUNT;
    logic [ADDR_W-1:0]     i_cfg_data  = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_cfg_ready;

    fixed_block_pool_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Two copies of the pool model: one runs ahead while requests are
    // planned, the other follows the transactions the block actually takes.
    bit [IDX_W-1:0]   link_idx  [0:1][0:DEF_NUM_BLOCKS-1];
    bit               link_ok   [0:1][0:DEF_NUM_BLOCKS-1];
    bit               busy      [0:1][0:DEF_NUM_BLOCKS-1];
    bit [IDX_W-1:0]   head_idx  [0:1];
    bit               head_ok   [0:1];
    bit [COUNT_W-1:0] fresh_mark[0:1];
    bit [COUNT_W-1:0] pool_count[0:1];
    bit [ADDR_W-1:0]  pool_base [0:1];

    t_pool_req        request_queue[$];
    t_pool_reply      reply_queue[$];
    int unsigned      live_blocks[$];
    int unsigned      last_freed;
    bit               have_freed;
    int unsigned      idle_pct     = 0;
    bit               hold_request = 1'b0;
    int unsigned      fail_count   = 0;

    function automatic int unsigned pool_limit(int c);
        return (pool_count[c] > DEF_NUM_BLOCKS) ? DEF_NUM_BLOCKS : pool_count[c];
    endfunction

    function automatic void rebuild_pool(int c);
        for (int i = 0; i < DEF_NUM_BLOCKS; i++) begin
            busy[c][i] = 1'b0;
        end
        head_ok[c]    = 1'b0;
        head_idx[c]   = '0;
        fresh_mark[c] = '0;
    endfunction

    function automatic t_pool_reply predict_pool_reply(int c, logic cmd,
                                                       logic [ADDR_W-1:0] addr);
        t_pool_reply       r;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] blk;
        logic [IDX_W-1:0]  idx;
        r.addr   = '0;
        r.status = STATUS_OK;
        idx      = '0;
        if (cmd == CMD_ALLOC) begin
            if (head_ok[c]) begin
                idx         = head_idx[c];
                head_ok[c]  = link_ok[c][idx];
                head_idx[c] = link_idx[c][idx];
            end else if (fresh_mark[c] < pool_limit(c)) begin
                idx           = fresh_mark[c][IDX_W-1:0];
                fresh_mark[c] = fresh_mark[c] + 1'b1;
            end else begin
                r.status = STATUS_EMPTY;
            end
            if (r.status == STATUS_OK) begin
                busy[c][idx] = 1'b1;
                r.addr = pool_base[c] + (ADDR_W'(idx) << BLOCK_SHIFT);
            end
        end else begin
            off = addr - pool_base[c];
            blk = off >> BLOCK_SHIFT;
            if (addr != '0 && off[BLOCK_SHIFT-1:0] == '0 && blk < pool_limit(c)
                    && busy[c][blk[IDX_W-1:0]]) begin
                idx             = blk[IDX_W-1:0];
                busy[c][idx]    = 1'b0;
                link_idx[c][idx] = head_idx[c];
                link_ok[c][idx]  = head_ok[c];
                head_idx[c]     = idx;
                head_ok[c]      = 1'b1;
            end else begin
                r.status = STATUS_REJECTED;
            end
        end
        return r;
    endfunction

    // Runs the request through the planning copy so that later frees can
    // name blocks that will really be out at that point.
    task automatic queue_request(input logic cmd, input logic [ADDR_W-1:0] addr);
        t_pool_reply r;
        t_pool_req   q;
        int unsigned idx;
        r = predict_pool_reply(PLAN_COPY, cmd, addr);
        if (r.status == STATUS_OK) begin
            idx = ((cmd == CMD_ALLOC ? r.addr : addr) - pool_base[PLAN_COPY]) >> BLOCK_SHIFT;
            if (cmd == CMD_ALLOC) begin
                live_blocks.push_back(idx);
            end else begin
                foreach (live_blocks[i]) begin
                    if (live_blocks[i] == idx) begin
                        live_blocks.delete(i);
                        break;
                    end
                end
                last_freed = idx;
                have_freed = 1'b1;
            end
        end
        q.cmd  = cmd;
        q.addr = addr;
        request_queue.push_back(q);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || reply_queue.size() != 0 || i_s_tvalid);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        for (int c = 0; c < 2; c++) begin
            if (idx == CFG_BLOCK_COUNT) begin
                pool_count[c] = value[COUNT_W-1:0];
                rebuild_pool(c);
            end else begin
                pool_base[c] = value;
            end
        end
        if (idx == CFG_BLOCK_COUNT) begin
            live_blocks.delete();
            have_freed = 1'b0;
        end
        @(negedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 4095);
            2:       return ADDR_W'($urandom_range(0, 65535)) << BLOCK_SHIFT;
            default: return ADDR_W'($urandom_range(0, 200));
        endcase
    endfunction

    task automatic queue_mix(input int unsigned n);
        int unsigned       r;
        logic [ADDR_W-1:0] base;
        base = pool_base[PLAN_COPY];
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 80 && live_blocks.size() == 0)) begin
                queue_request(CMD_ALLOC, $urandom);
            end else if (r < 80) begin
                queue_request(CMD_FREE, base + (ADDR_W'(live_blocks[
                    $urandom_range(0, live_blocks.size() - 1)]) << BLOCK_SHIFT));
            end else if (r < 85 && have_freed) begin
                queue_request(CMD_FREE, base + (ADDR_W'(last_freed) << BLOCK_SHIFT));
            end else if (r < 90) begin
                queue_request(CMD_FREE, base + (ADDR_W'($urandom_range(0, 1023)) << BLOCK_SHIFT)
                                        + ADDR_W'($urandom_range(1, BLOCK_BYTES - 1)));
            end else if (r < 95) begin
                queue_request(CMD_FREE, base + (ADDR_W'(pool_limit(PLAN_COPY)
                                        + $urandom_range(0, 100)) << BLOCK_SHIFT));
            end else begin
                queue_request(CMD_FREE, $urandom_range(0, 1) ? $urandom : '0);
            end
        end
    endtask

    // Request driver.
    int unsigned send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                reply_queue.push_back(predict_pool_reply(CHECK_COPY, i_s_tuser, i_s_tdata));
                void'(request_queue.pop_front());
            end
            if (i_s_tvalid && !o_s_tready) begin
                // The offered transaction stays until the block takes it.
            end else if (send_gap > 0) begin
                send_gap--;
                i_s_tvalid <= 1'b0;
            end else if (request_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= request_queue[0].addr;
                i_s_tuser  <= request_queue[0].cmd;
            end else begin
                if (request_queue.size() != 0) send_gap = $urandom_range(0, 3);
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off on request.
    int unsigned ready_gap = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_m_tready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            i_m_tready <= 1'b0;
        end else if (i_rst_n && $urandom_range(0, 99) < idle_pct) begin
            ready_gap = $urandom_range(0, 3);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= i_rst_n;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_pool_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (reply_queue.size() == 0) begin
                $error("result with nothing expected: tdata=%h", o_m_tdata);
                fail_count++;
            end else begin
                want = reply_queue.pop_front();
                if (o_m_tdata[ADDR_W-1:0] !== want.addr) begin
                    $error("block_address: expected %h, actual %h",
                           want.addr, o_m_tdata[ADDR_W-1:0]);
                    fail_count++;
                end
                if (o_m_tdata[ADDR_W+STATUS_W-1:ADDR_W] !== want.status) begin
                    $error("status: expected %0d, actual %0d",
                           want.status, o_m_tdata[ADDR_W+STATUS_W-1:ADDR_W]);
                    fail_count++;
                end
                if (o_m_tdata[OUT_DATA_W-1:ADDR_W+STATUS_W] !== '0) begin
                    $error("pad: expected 0, actual %h",
                           o_m_tdata[OUT_DATA_W-1:ADDR_W+STATUS_W]);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run when no transaction of any kind moves for too long.
    int unsigned stuck_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("fixed_block_pool_allocator: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [COUNT_W-1:0] cnt;
        for (int c = 0; c < 2; c++) begin
            pool_count[c] = RESET_BLOCK_COUNT;
            pool_base[c]  = '0;
            rebuild_pool(c);
        end
        have_freed = 1'b0;
        last_freed = 0;
        idle_pct   = 20;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Base 0: block 0 sits at the null address.
        queue_request(CMD_ALLOC, 32'hFFFF_FFFF);
        queue_request(CMD_ALLOC, '0);
        queue_request(CMD_ALLOC, 32'h1234_5678);
        queue_request(CMD_FREE,  32'h0000_0000);
        queue_request(CMD_FREE,  32'h0000_0021);
        queue_request(CMD_FREE,  32'h0000_8000);
        queue_request(CMD_FREE,  32'h0000_0060);
        queue_request(CMD_FREE,  32'h0000_0020);
        queue_request(CMD_FREE,  32'h0000_0020);
        queue_request(CMD_FREE,  32'h0000_0040);
        queue_request(CMD_ALLOC, '0);
        queue_request(CMD_ALLOC, '0);
        queue_request(CMD_ALLOC, '0);
        queue_request(CMD_FREE,  32'hFFFF_FFFF);
        queue_request(CMD_FREE,  32'hFFFF_FFE0);
        wait_drained();

        // Moving the base keeps the pool; block 2 now wraps to null.
        write_register(CFG_AREA_BASE, 32'hFFFF_FFC0);
        queue_request(CMD_FREE,  32'hFFFF_FFE0);
        queue_request(CMD_FREE,  32'h0000_0000);
        queue_request(CMD_ALLOC, '0);
        wait_drained();

        write_register(CFG_BLOCK_COUNT, 32'h0000_07FF);
        queue_request(CMD_ALLOC, '0);
        wait_drained();
        write_register(CFG_BLOCK_COUNT, 32'd3);
        repeat (4) queue_request(CMD_ALLOC, $urandom);
        queue_request(CMD_FREE, 32'hFFFF_FFC0);
        queue_request(CMD_FREE, 32'h0000_0000);
        wait_drained();

        write_register(CFG_BLOCK_COUNT, 32'd0);
        queue_request(CMD_ALLOC, '0);
        queue_request(CMD_FREE,  32'hFFFF_FFE0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       cnt = 11'd1;
                1:       cnt = 11'd1024;
                2:       cnt = 11'h7FF;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       cnt = COUNT_W'($urandom_range(2, 8));
                        1:       cnt = COUNT_W'($urandom_range(9, 64));
                        2:       cnt = COUNT_W'($urandom_range(65, 1024));
                        default: cnt = COUNT_W'($urandom_range(1, 2047));
                    endcase
                end
            endcase
            case (p % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 30;
            endcase
            if (p == PHASES - 1) idle_pct = 0;
            write_register(CFG_AREA_BASE, pick_base());
            write_register(CFG_BLOCK_COUNT, ADDR_W'(cnt));
            queue_mix(PHASE_ITEMS / 2);
            // With the first half queued, stall the results for a long while
            // so that the block backs up into the request side.
            if (p == 1) hold_request = 1'b1;
            if ($urandom_range(0, 1)) begin
                wait_drained();
                write_register(CFG_AREA_BASE, pick_base());
            end
            queue_mix(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("fixed_block_pool_allocator: match");
        end else begin
            $display("fixed_block_pool_allocator: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
design/fbpa_pkg.sv
design/fbpa_addr_check.sv
design/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_tb.sv
